@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ rtl/afc_pkg.sv @@
// Package for the frustum cull block: widths, codes and stage types
package afc_pkg;
    localparam int MatDepth    = 16;
    localparam int MatIdxW     = 4;
    localparam int ValW        = 32;
    localparam int HeightW     = 31;
    localparam int CornerCount = 8;
    localparam int PlaneCount  = 6;
    localparam int TdataInW    = 88;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    typedef logic signed [63:0] acc_t;
endpackage

@@ rtl/aabb_frustum_cull.sv @@
// Frustum cull top level: matrix store and the corner test pipeline
// Tile boxes stream in at one transfer per cycle when the output is not
// stalled; a load transfer writes one matrix element and gives no output.
// Six register stages (offsets, corner coordinates, products, row sums,
// plane tests, output) carry each test transfer to the culled flag. A full
// output with the downstream stalled freezes the whole pipeline. Matrix
// loads take effect for test transfers accepted after them.
`include "assert_macros.svh"
module aabb_frustum_cull
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [HeightW-1:0]    cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: matrix_index[3:0], matrix_value[35:4], scale_xz[51:36],
    //        offset_x[67:52], offset_z[83:68], zero fill
    input  logic [TdataInW-1:0]   s_axis_tdata,
    // tuser: func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: culled, zero fill
    output logic [7:0]            m_axis_tdata
);
    logic [HeightW-1:0] box_height_reg;
    logic [ValW-1:0]    mat_reg [MatDepth];
    logic               adv;
    logic               in_fire;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_height_reg <= '0;
            for (int n = 0; n < MatDepth; n++)
                mat_reg[n] <= '0;
        end
        else
        begin
            if (cfg_we)
                box_height_reg <= cfg_wdata;
            if (in_fire && s_axis_tuser == FUNC_LOAD)
                mat_reg[s_axis_tdata[MatIdxW-1:0]] <= s_axis_tdata[35:4];
        end
    end

    // stage 1: capture
    logic               v1_reg;
    logic [15:0]        sc1_reg;
    logic signed [16:0] ox1_reg, oz1_reg;
    logic [ValW-1:0]    m1_reg [MatDepth];
    logic [HeightW-1:0] h1_reg;
    // stage 2: corner coordinates (x0,x1,z0,z1)
    logic               v2_reg;
    logic signed [33:0] x2_reg [2];
    logic signed [33:0] z2_reg [2];
    logic [ValW-1:0]    m2_reg [MatDepth];
    logic [HeightW-1:0] h2_reg;
    // stage 3: per-row products
    logic               v3_reg;
    acc_t               px3_reg [4][2];
    acc_t               pz3_reg [4][2];
    acc_t               py3_reg [4];
    acc_t               pc3_reg [4];
    // stage 4: corner clip coordinates
    logic               v4_reg;
    acc_t               c4_reg [CornerCount][4];
    // stage 5: plane flags
    logic               v5_reg;
    logic [PlaneCount-1:0] out5_reg [CornerCount];
    logic               cull_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_fire && s_axis_tuser == FUNC_TEST;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            m_axis_tvalid <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc1_reg <= s_axis_tdata[51:36];
            ox1_reg <= 17'($signed(s_axis_tdata[67:52]));
            oz1_reg <= 17'($signed(s_axis_tdata[83:68]));
            m1_reg  <= mat_reg;
            h1_reg  <= box_height_reg;

            for (int i = 0; i < 2; i++)
            begin
                x2_reg[i] <= 34'($signed({1'b0, sc1_reg}) * (ox1_reg + 17'(i)));
                z2_reg[i] <= 34'($signed({1'b0, sc1_reg}) * (oz1_reg + 17'(i)));
            end
            m2_reg <= m1_reg;
            h2_reg <= h1_reg;

            for (int r = 0; r < 4; r++)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    px3_reg[r][i] <= 64'($signed(m2_reg[r*4]) * x2_reg[i]);
                    pz3_reg[r][i] <= 64'($signed(m2_reg[r*4+2]) * z2_reg[i]);
                end
                py3_reg[r] <= 64'($signed(m2_reg[r*4+1]) * $signed({1'b0, h2_reg})) >>> 16;
                pc3_reg[r] <= 64'($signed(m2_reg[r*4+3]));
            end

            for (int q = 0; q < CornerCount; q++)
                for (int r = 0; r < 4; r++)
                    c4_reg[q][r] <= px3_reg[r][q[2]] + pz3_reg[r][q[1]]
                                  + (q[0] ? py3_reg[r] : 64'sd0) + pc3_reg[r];

            for (int q = 0; q < CornerCount; q++)
                for (int a = 0; a < 3; a++)
                begin
                    out5_reg[q][a*2]   <= c4_reg[q][a] < -c4_reg[q][3];
                    out5_reg[q][a*2+1] <= c4_reg[q][a] > c4_reg[q][3];
                end

            cull_reg <= |(out5_reg[0] & out5_reg[1] & out5_reg[2] & out5_reg[3]
                        & out5_reg[4] & out5_reg[5] & out5_reg[6] & out5_reg[7]);
        end
    end

    assign m_axis_tdata = {7'd0, cull_reg};

    `ASSERT_CLK(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(cull_reg), "output changed under stall")
    `ASSERT_CLK(a_load_no_out, clk, rst_n, in_fire && s_axis_tuser == FUNC_LOAD |=> !v1_reg, "load produced an item")
    `ASSERT_CLK(a_ready, clk, rst_n, !m_axis_tvalid |-> s_axis_tready, "stalled with empty output")
endmodule
